// ===== sv/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcr_pkg
// shared types and constants of the manchester channel receiver
// ----------------------------------------------------------------------------
package mcr_pkg;

    localparam int TIME_BITS_DEF   = 16;
    localparam int FRAME_BYTES_DEF = 258;

    localparam int CFG_W         = 16;
    localparam int CFG_INDEX_W   = 8;
    localparam int BYTE_W        = 8;
    localparam int BYTE_INDEX_W  = 9;
    localparam int STATE_W       = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_FULL_BIT_LOW  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FULL_BIT_HIGH = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_BIT_LOW  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_BIT_HIGH = 8'd3;

    localparam logic [CFG_W-1:0] FULL_BIT_LOW_RST  = 16'd14400;
    localparam logic [CFG_W-1:0] FULL_BIT_HIGH_RST = 16'd17600;
    localparam logic [CFG_W-1:0] HALF_BIT_LOW_RST  = 16'd7200;
    localparam logic [CFG_W-1:0] HALF_BIT_HIGH_RST = 16'd8800;

    localparam logic [STATE_W-1:0] CH_IDLE      = 2'd0;
    localparam logic [STATE_W-1:0] CH_BUSY      = 2'd1;
    localparam logic [STATE_W-1:0] CH_COLLISION = 2'd2;

    localparam logic MODE_EDGE    = 1'b0;
    localparam logic MODE_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] full_bit_low;
        logic [CFG_W-1:0] full_bit_high;
        logic [CFG_W-1:0] half_bit_low;
        logic [CFG_W-1:0] half_bit_high;
    } cfg_t;

    typedef struct packed {
        logic [STATE_W-1:0]      channel_state;
        logic                    byte_valid;
        logic [BYTE_W-1:0]       byte_value;
        logic [BYTE_INDEX_W-1:0] byte_index;
        logic                    message_done;
    } rslt_t;

endpackage

// ===== sv/mcr_item_if.sv =====
// ----------------------------------------------------------------------------
// mcr_item_if
// input beat channel: line edge or timeout event
// ----------------------------------------------------------------------------
interface mcr_item_if #(
    parameter int TIME_BITS = mcr_pkg::TIME_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [TIME_BITS-1:0] capture_time;
    logic                 line_level;

    modport source (output valid, mode, capture_time, line_level, input ready);
    modport sink   (input valid, mode, capture_time, line_level, output ready);
endinterface

// ===== sv/mcr_result_if.sv =====
// ----------------------------------------------------------------------------
// mcr_result_if
// result beat channel: channel state and completed byte
// ----------------------------------------------------------------------------
interface mcr_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [mcr_pkg::STATE_W-1:0]          channel_state;
    logic                                 byte_valid;
    logic [mcr_pkg::BYTE_W-1:0]           byte_value;
    logic [mcr_pkg::BYTE_INDEX_W-1:0]     byte_index;
    logic                                 message_done;

    modport source (output valid, channel_state, byte_valid, byte_value, byte_index,
                    message_done, input ready);
    modport sink   (input valid, channel_state, byte_valid, byte_value, byte_index,
                    message_done, output ready);
endinterface

// ===== sv/mcr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mcr_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface mcr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mcr_pkg::CFG_INDEX_W-1:0]   index;
    logic [mcr_pkg::CFG_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/mcr_frame_tracker.sv =====
// ----------------------------------------------------------------------------
// mcr_frame_tracker
// channel state, bit timing and byte assembly; one beat per step
// ----------------------------------------------------------------------------
module mcr_frame_tracker #(
    parameter int TIME_BITS   = mcr_pkg::TIME_BITS_DEF,
    parameter int FRAME_BYTES = mcr_pkg::FRAME_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  mode,
    input  logic [TIME_BITS-1:0]  capture_time,
    input  logic                  line_level,
    input  mcr_pkg::cfg_t         cfg,
    output mcr_pkg::rslt_t        result
);

    localparam int CMP_W = (TIME_BITS > mcr_pkg::CFG_W) ? TIME_BITS : mcr_pkg::CFG_W;
    localparam int CNT_W = mcr_pkg::BYTE_INDEX_W;
    localparam int BW    = mcr_pkg::BYTE_W;

    typedef enum logic [mcr_pkg::STATE_W-1:0] {
        ST_IDLE      = mcr_pkg::CH_IDLE,
        ST_BUSY      = mcr_pkg::CH_BUSY,
        ST_COLLISION = mcr_pkg::CH_COLLISION
    } chan_t;

    chan_t                 chan_reg, chan_next;
    logic [TIME_BITS-1:0]  last_edge_reg, last_edge_next;
    logic                  cur_bit_reg, cur_bit_next;
    logic                  half_phase_reg, half_phase_next;
    logic [CNT_W-1:0]      byte_count_reg, byte_count_next;
    logic [2:0]            bit_pos_reg, bit_pos_next;
    logic [BW-1:0]         asm_reg, asm_next;
    logic [BW-1:0]         plen_reg, plen_next;
    logic                  level_reg, level_next;

    logic [TIME_BITS-1:0]  spacing;
    logic [CMP_W-1:0]      spacing_x;
    logic                  is_full;
    logic                  is_half;
    logic                  put;
    logic                  put_val;
    logic [BW-1:0]         asm_put;
    logic                  byte_done;
    logic [CNT_W:0]        count_inc;
    logic [BW-1:0]         plen_eff;
    logic                  frame_done;

    assign spacing   = capture_time - last_edge_reg;
    assign spacing_x = CMP_W'(spacing);
    assign is_full   = (spacing_x >= CMP_W'(cfg.full_bit_low))
                    && (spacing_x <= CMP_W'(cfg.full_bit_high));
    assign is_half   = !is_full
                    && (spacing_x >= CMP_W'(cfg.half_bit_low))
                    && (spacing_x <= CMP_W'(cfg.half_bit_high));
    assign count_inc = {1'b0, byte_count_reg} + (CNT_W+1)'(1);

    always_comb
    begin
        chan_next       = chan_reg;
        last_edge_next  = last_edge_reg;
        cur_bit_next    = cur_bit_reg;
        half_phase_next = half_phase_reg;
        byte_count_next = byte_count_reg;
        bit_pos_next    = bit_pos_reg;
        asm_next        = asm_reg;
        plen_next       = plen_reg;
        level_next      = level_reg;
        put             = 1'b0;
        put_val         = 1'b0;
        asm_put         = asm_reg;
        byte_done       = 1'b0;
        plen_eff        = plen_reg;
        frame_done      = 1'b0;

        if (mode == mcr_pkg::MODE_EDGE)
        begin
            level_next = line_level;
            unique case (chan_reg)
                ST_IDLE:
                begin
                    // frame start: first bit is zero at the top bit position
                    chan_next       = ST_BUSY;
                    last_edge_next  = capture_time;
                    cur_bit_next    = 1'b0;
                    half_phase_next = 1'b0;
                    byte_count_next = '0;
                    bit_pos_next    = 3'd6;
                    plen_next       = '0;
                    asm_next        = asm_reg & ~(BW'(1) << 7);
                end
                ST_BUSY:
                begin
                    last_edge_next = capture_time;
                    if (is_full)
                    begin
                        cur_bit_next = ~cur_bit_reg;
                        put          = 1'b1;
                        put_val      = ~cur_bit_reg;
                    end
                    else if (is_half)
                    begin
                        half_phase_next = ~half_phase_reg;
                        put             = half_phase_reg;
                        put_val         = cur_bit_reg;
                    end
                    if (put)
                    begin
                        asm_put = asm_reg;
                        asm_put[bit_pos_reg] = put_val;
                        asm_next     = asm_put;
                        bit_pos_next = bit_pos_reg - 3'd1;
                        if (bit_pos_reg == 3'd0)
                        begin
                            byte_done = 1'b1;
                            byte_count_next = (count_inc >= (CNT_W+1)'(FRAME_BYTES))
                                            ? '0 : count_inc[CNT_W-1:0];
                            if (byte_count_reg == CNT_W'(1))
                            begin
                                plen_eff = asm_put;
                            end
                            plen_next = plen_eff;
                            if ((plen_eff != '0)
                                && (byte_count_reg == ({1'b0, plen_eff} + CNT_W'(1))))
                            begin
                                frame_done      = 1'b1;
                                cur_bit_next    = 1'b0;
                                half_phase_next = 1'b0;
                                byte_count_next = '0;
                                bit_pos_next    = 3'd7;
                            end
                        end
                    end
                end
                ST_COLLISION:
                begin
                    chan_next = ST_BUSY;
                end
                default:
                begin
                    chan_next = chan_reg;
                end
            endcase
        end
        else if (chan_reg == ST_BUSY)
        begin
            chan_next = level_reg ? ST_IDLE : ST_COLLISION;
        end
    end

    always_comb
    begin
        result.channel_state = chan_next;
        result.byte_valid    = byte_done;
        result.byte_value    = byte_done ? asm_put : '0;
        result.byte_index    = byte_done ? byte_count_reg : '0;
        result.message_done  = frame_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg       <= ST_IDLE;
            last_edge_reg  <= '0;
            cur_bit_reg    <= 1'b0;
            half_phase_reg <= 1'b0;
            byte_count_reg <= '0;
            bit_pos_reg    <= 3'd7;
            asm_reg        <= '0;
            plen_reg       <= '0;
            level_reg      <= 1'b1;
        end
        else if (step)
        begin
            chan_reg       <= chan_next;
            last_edge_reg  <= last_edge_next;
            cur_bit_reg    <= cur_bit_next;
            half_phase_reg <= half_phase_next;
            byte_count_reg <= byte_count_next;
            bit_pos_reg    <= bit_pos_next;
            asm_reg        <= asm_next;
            plen_reg       <= plen_next;
            level_reg      <= level_next;
        end
    end

endmodule

// ===== sv/manchester_channel_receiver.sv =====
// ----------------------------------------------------------------------------
// manchester_channel_receiver
// manchester line decoder with channel idle / busy / collision tracking
// ----------------------------------------------------------------------------
// Each input beat (a timestamped line edge or a timeout) produces exactly one
// result beat: the beat is captured in an input register, decoded in one pass
// against the bit-timing windows and the frame state, and the result lands in
// an output register. A new beat is accepted every cycle while results are
// taken; the input register keeps accepting one more beat while a result waits.
// Registers are to be written by the user through the cfg channel only while
// the block is idle, not enforced by the block; they take effect on the next beat.
module manchester_channel_receiver #(
    parameter int TIME_BITS   = mcr_pkg::TIME_BITS_DEF,
    parameter int FRAME_BYTES = mcr_pkg::FRAME_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    mcr_item_if.sink     item,
    mcr_result_if.source result,
    mcr_cfg_if.sink      cfg
);

    mcr_pkg::cfg_t         cfg_reg;
    logic                  in_valid_reg;
    logic                  in_mode_reg;
    logic [TIME_BITS-1:0]  in_time_reg;
    logic                  in_level_reg;
    logic                  out_valid_reg;
    mcr_pkg::rslt_t        out_reg;
    mcr_pkg::rslt_t        step_result;
    logic                  advance;
    logic                  step;

    assign advance = !out_valid_reg || result.ready;
    assign step    = in_valid_reg && advance;
    assign item.ready = !in_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    mcr_frame_tracker #(
        .TIME_BITS   (TIME_BITS),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .mode         (in_mode_reg),
        .capture_time (in_time_reg),
        .line_level   (in_level_reg),
        .cfg          (cfg_reg),
        .result       (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_bit_low  <= mcr_pkg::FULL_BIT_LOW_RST;
            cfg_reg.full_bit_high <= mcr_pkg::FULL_BIT_HIGH_RST;
            cfg_reg.half_bit_low  <= mcr_pkg::HALF_BIT_LOW_RST;
            cfg_reg.half_bit_high <= mcr_pkg::HALF_BIT_HIGH_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                mcr_pkg::REG_FULL_BIT_LOW:  cfg_reg.full_bit_low  <= cfg.data;
                mcr_pkg::REG_FULL_BIT_HIGH: cfg_reg.full_bit_high <= cfg.data;
                mcr_pkg::REG_HALF_BIT_LOW:  cfg_reg.half_bit_low  <= cfg.data;
                mcr_pkg::REG_HALF_BIT_HIGH: cfg_reg.half_bit_high <= cfg.data;
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_mode_reg  <= item.mode;
            in_time_reg  <= item.capture_time;
            in_level_reg <= item.line_level;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= step_result;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.channel_state = out_reg.channel_state;
    assign result.byte_valid    = out_reg.byte_valid;
    assign result.byte_value    = out_reg.byte_value;
    assign result.byte_index    = out_reg.byte_index;
    assign result.message_done  = out_reg.message_done;

endmodule

// ===== bench/tb_manchester_channel_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_manchester_channel_receiver
// self-checking bench for the manchester channel receiver
// ----------------------------------------------------------------------------
// A short table of line events walks the channel through idle, busy and
// collision, timestamp wrap and a first byte. Random framed traffic follows
// under several bit-timing windows: well-formed frames with random length
// and content, cut frames, stray edges and noise. Every result beat is
// compared field by field with a pinned table value or a decoder kept inside
// the bench. Both sides idle in random bursts, the receiver holds off for a
// long stretch in each phase, and the sender pauses to let the block drain.
// ----------------------------------------------------------------------------
module tb_manchester_channel_receiver;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 60;
    localparam logic [mcr_pkg::CFG_INDEX_W-1:0] REG_NONE = 8'hFF;

    typedef struct {
        logic           mode;
        logic [15:0]    stamp;
        logic           level;
        bit             pinned;
        mcr_pkg::rslt_t want;
    } probe_t;

    typedef struct {
        bit             pinned;
        mcr_pkg::rslt_t want;
    } pin_t;

    localparam mcr_pkg::rslt_t R_IDLE = '{mcr_pkg::CH_IDLE, 1'b0, 8'h00, 9'd0, 1'b0};
    localparam mcr_pkg::rslt_t R_BUSY = '{mcr_pkg::CH_BUSY, 1'b0, 8'h00, 9'd0, 1'b0};
    localparam mcr_pkg::rslt_t R_COLL = '{mcr_pkg::CH_COLLISION, 1'b0, 8'h00, 9'd0, 1'b0};
    localparam mcr_pkg::rslt_t R_BYTE = '{mcr_pkg::CH_BUSY, 1'b1, 8'h6A, 9'd0, 1'b0};

    logic clk;
    logic rst_n;

    mcr_item_if #(.TIME_BITS(mcr_pkg::TIME_BITS_DEF)) item_ch ();
    mcr_result_if result_ch ();
    mcr_cfg_if cfg_ch ();

    manchester_channel_receiver uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // decoder copy of the block
    logic [mcr_pkg::CFG_W-1:0]        full_lo, full_hi, half_lo, half_hi;
    logic [mcr_pkg::STATE_W-1:0]      chan;
    logic [15:0]                      last_edge;
    logic                             cur_bit;
    logic                             half_ph;
    logic [mcr_pkg::BYTE_INDEX_W-1:0] byte_cnt;
    logic [2:0]                       bit_pos;
    logic [7:0]                       shift_byte;
    logic [7:0]                       pay_len;
    logic                             last_level;

    mcr_pkg::rslt_t expected_decodes[$];
    pin_t           typed_decodes[$];
    probe_t         probes[22];

    int    mismatches = 0;
    int    cycles = 0;
    int    beats_in = 0;
    int    offered = 0;
    int    bytes_seen = 0;
    int    frames_done = 0;
    int    collisions = 0;
    int    send_quiet = 0;
    bit    calm = 0;
    bit    long_hold = 0;
    logic [15:0] line_stamp = '0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void clear_frame();
        cur_bit  = 1'b0;
        half_ph  = 1'b0;
        byte_cnt = '0;
        bit_pos  = 3'd7;
    endfunction

    function automatic logic shift_in(input logic b, output logic [7:0] v,
                                      output logic [mcr_pkg::BYTE_INDEX_W-1:0] ix);
        v  = '0;
        ix = '0;
        shift_byte[bit_pos] = b;
        if (bit_pos != 3'd0)
        begin
            bit_pos = bit_pos - 3'd1;
            return 1'b0;
        end
        bit_pos = 3'd7;
        v  = shift_byte;
        ix = byte_cnt;
        byte_cnt = (int'(byte_cnt) + 1 >= mcr_pkg::FRAME_BYTES_DEF) ? '0 : byte_cnt + 1'b1;
        return 1'b1;
    endfunction

    function automatic mcr_pkg::rslt_t decode_line_event(input logic mode,
                                                         input logic [15:0] t,
                                                         input logic lvl);
        mcr_pkg::rslt_t                   r;
        logic                             got;
        logic [7:0]                       v;
        logic [mcr_pkg::BYTE_INDEX_W-1:0] ix;
        logic [15:0]                      gap;
        r   = '0;
        got = 1'b0;
        v   = '0;
        ix  = '0;
        if (mode == mcr_pkg::MODE_EDGE)
        begin
            if (chan == mcr_pkg::CH_IDLE)
            begin
                last_edge = t;
                chan = mcr_pkg::CH_BUSY;
                clear_frame();
                pay_len = '0;
                got = shift_in(1'b0, v, ix);
            end
            else if (chan == mcr_pkg::CH_BUSY)
            begin
                gap = t - last_edge;
                if (gap >= full_lo && gap <= full_hi)
                begin
                    cur_bit = ~cur_bit;
                    got = shift_in(cur_bit, v, ix);
                end
                else if (gap >= half_lo && gap <= half_hi)
                begin
                    half_ph = ~half_ph;
                    if (!half_ph)
                        got = shift_in(cur_bit, v, ix);
                end
                last_edge = t;
                if (got)
                begin
                    if (ix == 9'd1)
                        pay_len = v;
                    if (pay_len != 8'd0 && ix == {1'b0, pay_len} + 9'd1)
                    begin
                        r.message_done = 1'b1;
                        clear_frame();
                    end
                end
            end
            else
            begin
                chan = mcr_pkg::CH_BUSY;
            end
            last_level = lvl;
        end
        else if (chan == mcr_pkg::CH_BUSY)
        begin
            chan = last_level ? mcr_pkg::CH_IDLE : mcr_pkg::CH_COLLISION;
        end
        r.channel_state = chan;
        r.byte_valid    = got;
        if (got)
        begin
            r.byte_value = v;
            r.byte_index = ix;
        end
        return r;
    endfunction

    function automatic void restore_defaults();
        full_lo    = mcr_pkg::FULL_BIT_LOW_RST;
        full_hi    = mcr_pkg::FULL_BIT_HIGH_RST;
        half_lo    = mcr_pkg::HALF_BIT_LOW_RST;
        half_hi    = mcr_pkg::HALF_BIT_HIGH_RST;
        chan       = mcr_pkg::CH_IDLE;
        last_edge  = '0;
        shift_byte = '0;
        pay_len    = '0;
        last_level = 1'b1;
        clear_frame();
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 30)
            $display("bad %s at result %0d: got %0d, want %0d", what, beats_in, got, want);
    endtask

    // scoreboard
    always @(posedge clk)
    begin
        mcr_pkg::rslt_t want;
        mcr_pkg::rslt_t guess;
        pin_t           tag;
        if (rst_n)
        begin
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("manchester_channel_receiver: mismatch");
                $finish;
            end
            else
            begin
                if (result_ch.valid && result_ch.ready)
                begin
                    if (expected_decodes.size() == 0)
                    begin
                        flag_mismatch("unexpected beat", 1, 0);
                    end
                    else
                    begin
                        want = expected_decodes.pop_front();
                        if (result_ch.channel_state !== want.channel_state)
                            flag_mismatch("channel_state", result_ch.channel_state,
                                          want.channel_state);
                        if (result_ch.byte_valid !== want.byte_valid)
                            flag_mismatch("byte_valid", result_ch.byte_valid, want.byte_valid);
                        if (result_ch.byte_value !== want.byte_value)
                            flag_mismatch("byte_value", result_ch.byte_value, want.byte_value);
                        if (result_ch.byte_index !== want.byte_index)
                            flag_mismatch("byte_index", result_ch.byte_index, want.byte_index);
                        if (result_ch.message_done !== want.message_done)
                            flag_mismatch("message_done", result_ch.message_done,
                                          want.message_done);
                    end
                end
                if (item_ch.valid && item_ch.ready)
                begin
                    guess = decode_line_event(item_ch.mode, item_ch.capture_time,
                                              item_ch.line_level);
                    tag = typed_decodes.pop_front();
                    expected_decodes.push_back(tag.pinned ? tag.want : guess);
                    beats_in++;
                    bytes_seen  += guess.byte_valid;
                    frames_done += guess.message_done;
                    collisions  += (guess.channel_state == mcr_pkg::CH_COLLISION);
                end
                if (cfg_ch.valid && cfg_ch.ready)
                begin
                    case (cfg_ch.index)
                        mcr_pkg::REG_FULL_BIT_LOW:  full_lo = cfg_ch.data;
                        mcr_pkg::REG_FULL_BIT_HIGH: full_hi = cfg_ch.data;
                        mcr_pkg::REG_HALF_BIT_LOW:  half_lo = cfg_ch.data;
                        mcr_pkg::REG_HALF_BIT_HIGH: half_hi = cfg_ch.data;
                        default: ;
                    endcase
                end
            end
        end
    end

    // result sink with random stalls and long hold-offs
    initial
    begin
        int r;
        int quiet;
        quiet = 0;
        result_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (long_hold)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 0;
            end
            else if (!calm && quiet == 0 && r < 10)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                if (quiet > 0)
                    quiet--;
                else if (r == 10)
                    quiet = $urandom_range(50, 150);
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic offer_beat(input logic mode, input logic [15:0] t, input logic lvl,
                              input bit pinned, input mcr_pkg::rslt_t want);
        int   r;
        pin_t tag;
        if (!calm)
        begin
            if (send_quiet > 0)
            begin
                send_quiet--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 12)
                begin
                    item_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 11)) @(posedge clk);
                end
                else if (r == 12)
                begin
                    send_quiet = $urandom_range(40, 120);
                end
            end
        end
        tag.pinned = pinned;
        tag.want   = want;
        typed_decodes.push_back(tag);
        item_ch.valid        <= 1'b1;
        item_ch.mode         <= mode;
        item_ch.capture_time <= t;
        item_ch.line_level   <= lvl;
        offered++;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    task automatic line_edge(input logic [15:0] gap, input logic lvl);
        line_stamp = line_stamp + gap;
        offer_beat(mcr_pkg::MODE_EDGE, line_stamp, lvl, 0, '0);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_decodes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [mcr_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [mcr_pkg::CFG_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_gap(input logic [15:0] lo, input logic [15:0] hi);
        int span;
        span = int'(hi) - int'(lo);
        if (span < 0)
            return 16'($urandom);
        return 16'(int'(lo) + int'($urandom_range(span, 0)));
    endfunction

    // any state: an edge at level high then a timeout leaves the channel idle
    task automatic settle_line();
        line_edge(16'($urandom), 1'b1);
        offer_beat(mcr_pkg::MODE_TIMEOUT, 16'($urandom), 1'($urandom), 0, '0);
    endtask

    task automatic play_bytes(input logic [7:0] body[$], input bit broken);
        logic held;
        logic lvl;
        logic end_lvl;
        end_lvl = 1'b1;
        held = 1'b0;
        foreach (body[k])
        begin
            for (int b = 7; b >= 0; b--)
            begin
                lvl = 1'($urandom);
                if (k == body.size() - 1 && b == 0)
                begin
                    lvl = ($urandom_range(0, 4) != 0);
                    end_lvl = lvl;
                end
                if (k == 0 && b == 7)
                begin
                    line_stamp = 16'($urandom);
                    offer_beat(mcr_pkg::MODE_EDGE, line_stamp, lvl, 0, '0);
                end
                else if (body[k][b] != held)
                begin
                    line_edge(pick_gap(full_lo, full_hi), lvl);
                    held = body[k][b];
                end
                else
                begin
                    line_edge(pick_gap(half_lo, half_hi), 1'($urandom));
                    line_edge(pick_gap(half_lo, half_hi), lvl);
                end
                if (broken && $urandom_range(0, 40) == 0)
                    line_edge(16'($urandom), 1'($urandom));
            end
        end
        offer_beat(mcr_pkg::MODE_TIMEOUT, 16'($urandom), 1'($urandom), 0, '0);
        if (broken || !end_lvl)
            settle_line();
    endtask

    task automatic send_frame(input bit broken);
        logic [7:0] body[$];
        int         r;
        int         len;
        r = $urandom_range(0, 9);
        len = (r == 0) ? 0 : (r < 8 ? $urandom_range(1, 6) : $urandom_range(7, 40));
        body.push_back({1'b0, 7'($urandom)});
        body.push_back(8'(len));
        repeat ((len == 0) ? $urandom_range(0, 4) : len)
            body.push_back(8'($urandom));
        if (broken)
        begin
            while (body.size() > 1 && $urandom_range(0, 1) == 1)
                void'(body.pop_back());
        end
        play_bytes(body, broken);
    endtask

    task automatic random_traffic(input int count);
        int goal;
        int r;
        goal = offered + count;
        while (offered < goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                send_frame(0);
            end
            else if (r < 88)
            begin
                send_frame(1);
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                    offer_beat(1'($urandom), 16'($urandom), 1'($urandom), 0, '0);
                settle_line();
            end
        end
    endtask

    initial
    begin
        logic [mcr_pkg::CFG_W-1:0] windows[5][4];
        windows = '{
            '{16'd14400, 16'd17600, 16'd0,     16'd65535},
            '{16'd1000,  16'd1000,  16'd500,   16'd500},
            '{16'd65535, 16'd65535, 16'd0,     16'd0},
            '{16'd0,     16'd65535, 16'd65535, 16'd0},
            '{16'd14400, 16'd17600, 16'd7200,  16'd8800}
        };
        probes = '{
            '{mcr_pkg::MODE_TIMEOUT, 16'd0,     1'b0, 1'b1, R_IDLE},
            '{mcr_pkg::MODE_EDGE,    16'd0,     1'b1, 1'b1, R_BUSY},
            '{mcr_pkg::MODE_EDGE,    16'd16000, 1'b0, 1'b1, R_BUSY},
            '{mcr_pkg::MODE_EDGE,    16'd24000, 1'b1, 1'b1, R_BUSY},
            '{mcr_pkg::MODE_EDGE,    16'd32000, 1'b0, 1'b1, R_BUSY},
            '{mcr_pkg::MODE_EDGE,    16'd35000, 1'b0, 1'b1, R_BUSY},
            '{mcr_pkg::MODE_TIMEOUT, 16'd35000, 1'b1, 1'b1, R_COLL},
            '{mcr_pkg::MODE_TIMEOUT, 16'd0,     1'b0, 1'b1, R_COLL},
            '{mcr_pkg::MODE_EDGE,    16'd40000, 1'b1, 1'b1, R_BUSY},
            '{mcr_pkg::MODE_EDGE,    16'd51000, 1'b1, 1'b0, R_IDLE},
            '{mcr_pkg::MODE_EDGE,    16'd65000, 1'b0, 1'b0, R_IDLE},
            '{mcr_pkg::MODE_EDGE,    16'd15464, 1'b1, 1'b0, R_IDLE},
            '{mcr_pkg::MODE_EDGE,    16'd31464, 1'b0, 1'b0, R_IDLE},
            '{mcr_pkg::MODE_EDGE,    16'd47464, 1'b1, 1'b0, R_IDLE},
            '{mcr_pkg::MODE_EDGE,    16'd63464, 1'b1, 1'b1, R_BYTE},
            '{mcr_pkg::MODE_TIMEOUT, 16'd65535, 1'b0, 1'b1, R_IDLE},
            '{mcr_pkg::MODE_EDGE,    16'd65535, 1'b0, 1'b1, R_BUSY},
            '{mcr_pkg::MODE_EDGE,    16'd15999, 1'b0, 1'b0, R_IDLE},
            '{mcr_pkg::MODE_EDGE,    16'd23999, 1'b0, 1'b0, R_IDLE},
            '{mcr_pkg::MODE_TIMEOUT, 16'd0,     1'b1, 1'b1, R_COLL},
            '{mcr_pkg::MODE_EDGE,    16'd0,     1'b1, 1'b1, R_BUSY},
            '{mcr_pkg::MODE_TIMEOUT, 16'd65535, 1'b1, 1'b1, R_IDLE}
        };
        item_ch.valid        = 1'b0;
        item_ch.mode         = mcr_pkg::MODE_EDGE;
        item_ch.capture_time = '0;
        item_ch.line_level   = 1'b1;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = mcr_pkg::REG_FULL_BIT_LOW;
        cfg_ch.data          = '0;
        restore_defaults();
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (probes[i])
            offer_beat(probes[i].mode, probes[i].stamp, probes[i].level,
                       probes[i].pinned, probes[i].want);
        long_hold = 1;
        random_traffic(240);

        foreach (windows[p])
        begin
            drain();
            write_reg(mcr_pkg::REG_FULL_BIT_LOW,  windows[p][0]);
            write_reg(mcr_pkg::REG_FULL_BIT_HIGH, windows[p][1]);
            write_reg(mcr_pkg::REG_HALF_BIT_LOW,  windows[p][2]);
            write_reg(mcr_pkg::REG_HALF_BIT_HIGH, windows[p][3]);
            if (p == 4)
                write_reg(REG_NONE, 16'h0001);
            long_hold = 1;
            random_traffic(85);
            drain();
            if (p == 4)
                calm = 1;
            random_traffic(85);
        end

        drain();
        repeat (8) @(posedge clk);
        $display("covered %0d beats under 6 timing windows: %0d bytes, %0d frames closed,",
                 beats_in, bytes_seen, frames_done);
        $display("%0d collision results, long receiver hold-offs and drained pauses",
                 collisions);
        if (mismatches == 0)
            $display("manchester_channel_receiver: match");
        else
            $display("manchester_channel_receiver: mismatch");
        $finish;
    end

endmodule
